@@ rtl/core/ifs_chaos_game_histogram_assert.svh @@
// Assertion macros used by the checker file ifs_chk.sv.
`ifndef IFS_CHAOS_GAME_HISTOGRAM_ASSERT_SVH
`define IFS_CHAOS_GAME_HISTOGRAM_ASSERT_SVH

// same-cycle implication
`define IFS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IFS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ifs_pkg.sv @@
// Types, codes and constants for the chaos-game histogram block.
package ifs_pkg;

  localparam int IMAGE_WIDTH_DEF    = 512;
  localparam int IMAGE_HEIGHT_DEF   = 512;
  localparam int MAX_TRANSFORMS_DEF = 6;
  localparam int COUNT_BITS_DEF     = 24;

  localparam int COEF_WORDS = 6;
  localparam int BORDER     = 20;
  localparam int QDEPTH     = 2;

  localparam logic [2:0] WORD_E   = 3'd4;
  localparam logic [2:0] WORD_F   = 3'd5;
  localparam logic [2:0] WORD_THR = 3'd6;

  localparam logic [2:0] OP_WRITE   = 3'd0;
  localparam logic [2:0] OP_ITER    = 3'd1;
  localparam logic [2:0] OP_READ    = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_RESTART = 3'd4;

  localparam logic [1:0] CFG_COUNT = 2'd0;
  localparam logic [1:0] CFG_VMIN  = 2'd1;
  localparam logic [1:0] CFG_SX    = 2'd2;
  localparam logic [1:0] CFG_SY    = 2'd3;

  typedef enum logic [2:0] {
    K_NOP, K_ITER, K_READ, K_CLEAR, K_RESTART
  } kind_t;

  typedef struct packed {
    kind_t                       kind;
    logic [2:0]                  tsel;
    logic [COEF_WORDS-1:0][17:0] coef;
    logic [8:0]                  bin_x;
    logic [8:0]                  bin_y;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         count;
    logic signed [15:0] vmin;
    logic [15:0]        sx;
    logic [15:0]        sy;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [2:0]         used;
    logic [8:0]         pix_x;
    logic [8:0]         pix_y;
    logic               hit;
    logic [23:0]        count;
  } res_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

@@ rtl/core/ifs_front.sv @@
// Front end: accepts words, holds the transform table, picks the transform.
module ifs_front #(
  parameter int MAX_TRANSFORMS = ifs_pkg::MAX_TRANSFORMS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           op,
  input  logic [15:0]          frac,
  input  logic [2:0]           tsel,
  input  logic [2:0]           word,
  input  logic [17:0]          value,
  input  logic [8:0]           bin_x,
  input  logic [8:0]           bin_y,
  input  ifs_pkg::cfg_t        cfg,
  input  ifs_pkg::back_status_t st,
  input  logic                 q_full,
  output logic                 q_push,
  output ifs_pkg::cmd_t        q_cmd
);
  import ifs_pkg::*;

  localparam int TIW = (MAX_TRANSFORMS > 1) ? $clog2(MAX_TRANSFORMS) : 1;

  logic [17:0] thr_r  [MAX_TRANSFORMS];
  logic [17:0] coef_r [MAX_TRANSFORMS][COEF_WORDS];
  logic        acc;
  logic [2:0]  n;
  logic [2:0]  sel;
  logic        found;

  assign in_ready = !q_full && !st.init_busy;
  assign acc      = in_valid && in_ready;
  assign q_push   = acc;

  always_ff @(posedge clk) begin
    if (acc && op == OP_WRITE && 32'(tsel) < MAX_TRANSFORMS) begin
      if (word == WORD_THR) begin
        thr_r[tsel[TIW-1:0]] <= value;
      end else if (word < WORD_THR) begin
        coef_r[tsel[TIW-1:0]][word] <= value;
      end
    end
  end

  always_comb begin
    if (cfg.count == 3'd0) n = 3'd1;
    else if (32'(cfg.count) > MAX_TRANSFORMS) n = 3'(MAX_TRANSFORMS);
    else n = cfg.count;
    sel   = n - 3'd1;
    found = 1'b0;
    for (int i = 0; i < MAX_TRANSFORMS; i++) begin
      if (!found && i < 32'(n) && $signed({2'b00, frac}) < $signed(thr_r[i])) begin
        sel   = 3'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (op)
      OP_ITER:    q_cmd.kind = K_ITER;
      OP_READ:    q_cmd.kind = K_READ;
      OP_CLEAR:   q_cmd.kind = K_CLEAR;
      OP_RESTART: q_cmd.kind = K_RESTART;
      default:    q_cmd.kind = K_NOP;
    endcase
    q_cmd.tsel = sel;
    for (int w = 0; w < COEF_WORDS; w++) q_cmd.coef[w] = coef_r[sel[TIW-1:0]][w];
    q_cmd.bin_x = bin_x;
    q_cmd.bin_y = bin_y;
  end

endmodule

@@ rtl/core/ifs_queue.sv @@
// Short command queue between front and back.
module ifs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ifs_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output ifs_pkg::cmd_t dout
);
  import ifs_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  cmd_t          mem_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full  = cnt_r == CW'(QDEPTH);
  assign empty = cnt_r == '0;
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

@@ rtl/core/ifs_back.sv @@
// Back end: affine step, pixel mapping, histogram memory and result register.
module ifs_back #(
  parameter int IMAGE_WIDTH  = ifs_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = ifs_pkg::IMAGE_HEIGHT_DEF,
  parameter int COUNT_BITS   = ifs_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ifs_pkg::cfg_t         cfg,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  ifs_pkg::cmd_t         q_cmd,
  output ifs_pkg::back_status_t st,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ifs_pkg::res_t         out_res
);
  import ifs_pkg::*;

  localparam int DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_MUL, S_SUM, S_PIX, S_MAP, S_RD, S_OUT, S_CLR
  } state_t;

  state_t                  state_r;
  cmd_t                    cmd_r;
  logic signed [15:0]      x_r, y_r;
  logic signed [33:0]      p0_r, p1_r, p2_r, p3_r;
  logic signed [33:0]      qx_r, qy_r;
  logic [AW-1:0]           addr_r, clr_r;
  logic                    hit_r, rng_r;
  logic [8:0]              pix_x_r, pix_y_r;
  logic [COUNT_BITS-1:0]   rd_r;
  logic                    out_valid_r;
  res_t                    out_r;
  logic [COUNT_BITS-1:0]   mem [DEPTH];

  logic signed [35:0]      sum_x, sum_y, sh_x, sh_y;
  logic signed [15:0]      nx, ny;
  logic signed [16:0]      dx, dy;
  logic signed [33:0]      shx, shy;
  logic signed [17:0]      xp, yp;
  logic                    hit_c, rng_c;
  logic [AW-1:0]           ia, ra;
  logic [COUNT_BITS-1:0]   inc;
  logic [COUNT_BITS+23:0]  inc_ext, rd_ext;
  logic                    slot_free, we;
  logic [AW-1:0]           wa;
  logic [COUNT_BITS-1:0]   wd;

  assign q_pop        = (state_r == S_IDLE) && !q_empty;
  assign st.init_busy = state_r == S_INIT;
  assign out_valid    = out_valid_r;
  assign out_res      = out_r;
  assign slot_free    = !out_valid_r || out_ready;

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    if (v > 36'sd32767) return 16'sh7fff;
    if (v < -36'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  always_comb begin
    sum_x = 36'(p0_r) + 36'(p1_r) + (36'($signed(cmd_r.coef[WORD_E])) <<< 12) + 36'sd2048;
    sum_y = 36'(p2_r) + 36'(p3_r) + (36'($signed(cmd_r.coef[WORD_F])) <<< 12) + 36'sd2048;
    sh_x  = sum_x >>> 12;
    sh_y  = sum_y >>> 12;
    nx    = sat16(sh_x);
    ny    = sat16(sh_y);
    dx    = {x_r[15], x_r} - {cfg.vmin[15], cfg.vmin};
    dy    = {y_r[15], y_r} - {cfg.vmin[15], cfg.vmin};
    shx   = qx_r >>> 18;
    shy   = qy_r >>> 18;
    xp    = shx[17:0] + 18'(BORDER);
    yp    = shy[17:0] + 18'(BORDER);
    hit_c = xp > 18'(BORDER) && xp < 18'(IMAGE_WIDTH - BORDER) &&
            yp > 18'(BORDER) && yp < 18'(IMAGE_HEIGHT - BORDER);
    ia    = AW'(AW'(yp[12:0]) * AW'(IMAGE_WIDTH) + AW'(xp[12:0]));
    rng_c = 32'(cmd_r.bin_x) < IMAGE_WIDTH && 32'(cmd_r.bin_y) < IMAGE_HEIGHT;
    ra    = AW'(AW'(cmd_r.bin_y) * AW'(IMAGE_WIDTH) + AW'(cmd_r.bin_x));
    inc     = (rd_r == CMAX) ? rd_r : rd_r + 1'b1;
    inc_ext = {24'd0, inc};
    rd_ext  = {24'd0, rd_r};
  end

  always_comb begin
    we = 1'b0;
    wa = addr_r;
    wd = inc;
    if (state_r == S_INIT || state_r == S_CLR) begin
      we = 1'b1;
      wa = clr_r;
      wd = '0;
    end else if (state_r == S_OUT && slot_free && cmd_r.kind == K_ITER && hit_r) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_r       <= '0;
      x_r         <= '0;
      y_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_INIT, S_CLR: begin
          if (clr_r == AW'(DEPTH - 1)) begin
            clr_r   <= '0;
            state_r <= (state_r == S_INIT) ? S_IDLE : S_OUT;
          end else begin
            clr_r <= clr_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            cmd_r <= q_cmd;
            unique case (q_cmd.kind)
              K_ITER:    state_r <= S_MUL;
              K_READ:    state_r <= S_MAP;
              K_CLEAR:   state_r <= S_CLR;
              K_RESTART: begin
                x_r     <= '0;
                y_r     <= '0;
                state_r <= S_OUT;
              end
              default:   state_r <= S_OUT;
            endcase
          end
        end
        S_MUL: begin
          p0_r    <= x_r * $signed(cmd_r.coef[0]);
          p1_r    <= y_r * $signed(cmd_r.coef[1]);
          p2_r    <= x_r * $signed(cmd_r.coef[2]);
          p3_r    <= y_r * $signed(cmd_r.coef[3]);
          state_r <= S_SUM;
        end
        S_SUM: begin
          x_r     <= nx;
          y_r     <= ny;
          state_r <= S_PIX;
        end
        S_PIX: begin
          qx_r    <= dx * $signed({1'b0, cfg.sx});
          qy_r    <= dy * $signed({1'b0, cfg.sy});
          state_r <= S_MAP;
        end
        S_MAP: begin
          if (cmd_r.kind == K_ITER) begin
            addr_r  <= ia;
            hit_r   <= hit_c;
            pix_x_r <= hit_c ? xp[8:0] : 9'd0;
            pix_y_r <= hit_c ? yp[8:0] : 9'd0;
          end else begin
            addr_r  <= ra;
            hit_r   <= 1'b0;
            rng_r   <= rng_c;
            pix_x_r <= 9'd0;
            pix_y_r <= 9'd0;
          end
          state_r <= S_RD;
        end
        S_RD: state_r <= S_OUT;
        S_OUT: begin
          if (slot_free) begin
            out_valid_r     <= 1'b1;
            out_r.point_x   <= x_r;
            out_r.point_y   <= y_r;
            out_r.used      <= (cmd_r.kind == K_ITER) ? cmd_r.tsel : 3'd0;
            out_r.pix_x     <= (cmd_r.kind == K_ITER) ? pix_x_r : 9'd0;
            out_r.pix_y     <= (cmd_r.kind == K_ITER) ? pix_y_r : 9'd0;
            out_r.hit       <= (cmd_r.kind == K_ITER) && hit_r;
            if (cmd_r.kind == K_ITER && hit_r) out_r.count <= inc_ext[23:0];
            else if (cmd_r.kind == K_READ && rng_r) out_r.count <= rd_ext[23:0];
            else out_r.count <= 24'd0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/ifs_chaos_game_histogram.sv @@
// Top level of the chaos-game histogram renderer.
//
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    in_tdata, in_tuser (op)
//  out_     out  out_tvalid/out_tready  out_tdata, out_tuser (hit)
//  cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// Iterate runs in the back end as affine multiply, round, scale multiply,
// map, histogram read, update; read bin runs map, histogram read, output.
// Clear op sweeps the histogram one bin a cycle over all IMAGE_WIDTH*IMAGE_HEIGHT bins.
// After reset the same sweep runs, with in_tready held low.
// A two-entry queue lets the front accept words while the back stalls on out_tready.
module ifs_chaos_game_histogram #(
  parameter int IMAGE_WIDTH    = ifs_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT   = ifs_pkg::IMAGE_HEIGHT_DEF,
  parameter int MAX_TRANSFORMS = ifs_pkg::MAX_TRANSFORMS_DEF,
  parameter int COUNT_BITS     = ifs_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // random_fraction[15:0], table_transform[18:16], table_word[21:19],
  // table_value[39:22], bin_x[48:40], bin_y[57:49], zero fill
  input  logic [63:0] in_tdata,
  // op[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // point_x[15:0], point_y[31:16], transform_used[34:32], pixel_x[43:35],
  // pixel_y[52:44], bin_count[76:53], zero fill
  output logic [79:0] out_tdata,
  // hit[0]
  output logic [0:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ifs_pkg::*;

  cfg_t         cfg_r;
  back_status_t st;
  cmd_t         push_cmd, pop_cmd;
  logic         q_push, q_pop, q_full, q_empty;
  res_t         res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.count <= 3'd6;
      cfg_r.vmin  <= -16'sd8192;
      cfg_r.sx    <= 16'd7536;
      cfg_r.sy    <= 16'd7536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COUNT: cfg_r.count <= cfg_data[2:0];
        CFG_VMIN:  cfg_r.vmin  <= cfg_data;
        CFG_SX:    cfg_r.sx    <= cfg_data;
        CFG_SY:    cfg_r.sy    <= cfg_data;
        default:   ;
      endcase
    end
  end

  ifs_front #(.MAX_TRANSFORMS(MAX_TRANSFORMS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .op       (in_tuser),
    .frac     (in_tdata[15:0]),
    .tsel     (in_tdata[18:16]),
    .word     (in_tdata[21:19]),
    .value    (in_tdata[39:22]),
    .bin_x    (in_tdata[48:40]),
    .bin_y    (in_tdata[57:49]),
    .cfg      (cfg_r),
    .st       (st),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  ifs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (push_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (pop_cmd)
  );

  ifs_back #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT),
    .COUNT_BITS   (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_cmd     (pop_cmd),
    .st        (st),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {3'd0, res.count, res.pix_y, res.pix_x, res.used,
                      res.point_y, res.point_x};
  assign out_tuser = res.hit;

endmodule

@@ rtl/core/ifs_chk.sv @@
// Port-level checker for the histogram renderer, bound to the top level.
`include "ifs_chaos_game_histogram_assert.svh"

module ifs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [0:0]  out_tuser
);

  `IFS_ASSERT_NEXT(a_out_hold, clk, !rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result word changed while stalled")
  `IFS_ASSERT_NOW(a_hit_count, clk, !rst_n, out_tvalid && out_tuser[0], out_tdata[76:53] != 24'd0, "hit with zero count")
  `IFS_ASSERT_NOW(a_miss_pix, clk, !rst_n, out_tvalid && !out_tuser[0], out_tdata[52:35] == 18'd0, "pixel set without hit")
  `IFS_ASSERT_NEXT(a_rst_idle, clk, 1'b0, !rst_n, !out_tvalid, "result valid after reset")

endmodule

bind ifs_chaos_game_histogram ifs_chk u_chk (.*);
